/* rtl/pgse_pkg.sv */
`timescale 1ns / 1ps
package pgse_pkg;

	localparam int TimeW = 36;
	localparam int CordicIter = 28;
	localparam int CordicW = 34;
	localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

	typedef enum logic [2:0] {
		REG_DIR_X = 3'd0,
		REG_DIR_Y = 3'd1,
		REG_DIR_Z = 3'd2,
		REG_AMP = 3'd3,
		REG_SEP = 3'd4,
		REG_WID = 3'd5,
		REG_TE = 3'd6,
		REG_GAMMA = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] te;
		logic [31:0] sep;
		logic [31:0] wid;
	} fcfg_t;

	typedef struct packed {
		logic [31:0] dir_x;
		logic [31:0] dir_y;
		logic [31:0] dir_z;
		logic [31:0] amp;
		logic [31:0] gamma;
	} bcfg_t;

	typedef struct packed {
		logic signed [TimeW-1:0] net;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] dz;
		logic done;
	} step_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/pgse_front.sv */
`timescale 1ns / 1ps
module pgse_front (
	input  logic clk,
	input  logic arst_n,
	input  pgse_pkg::fcfg_t cfg,
	input  logic in_valid,
	output logic in_stall,
	input  logic [31:0] time_now,
	input  logic [31:0] time_prev,
	input  logic [31:0] disp_x,
	input  logic [31:0] disp_y,
	input  logic [31:0] disp_z,
	input  logic end_of_walker,
	input  logic queue_full,
	output logic push,
	output pgse_pkg::step_t push_item
);
	typedef struct packed {
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] dz;
		logic done;
	} carry_t;

	logic adv;
	logic v_s1, v_s2, v_s3;
	carry_t c_s1, c_s2, c_s3;
	logic signed [pgse_pkg::TimeW-1:0] lo_s1, hi_s1, pad_s1, big_s1, wid_s1;
	logic signed [pgse_pkg::TimeW-1:0] lo_s2, hi_s2, a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [pgse_pkg::TimeW-1:0] d1_s3, d2_s3;
	logic signed [pgse_pkg::TimeW-1:0] tn2, tp2, te2, p1, p2;

	assign adv = !v_s3 || !queue_full;
	assign in_stall = !adv;
	assign push = v_s3 && !queue_full;

	assign tn2 = {3'b0, time_now, 1'b0};
	assign tp2 = {3'b0, time_prev, 1'b0};
	assign te2 = {3'b0, cfg.te, 1'b0};
	assign p1 = d1_s3[pgse_pkg::TimeW-1] ? '0 : d1_s3;
	assign p2 = d2_s3[pgse_pkg::TimeW-1] ? '0 : d2_s3;

	always_comb begin
		push_item.net = p1 - p2;
		push_item.dx = c_s3.dx;
		push_item.dy = c_s3.dy;
		push_item.dz = c_s3.dz;
		push_item.done = c_s3.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= '{dx: disp_x, dy: disp_y, dz: disp_z, done: end_of_walker};
			lo_s1 <= tp2;
			hi_s1 <= (tn2 < te2) ? tn2 : te2;
			pad_s1 <= {4'b0, cfg.te} - {4'b0, cfg.sep} - {4'b0, cfg.wid};
			big_s1 <= {3'b0, cfg.sep, 1'b0};
			wid_s1 <= {3'b0, cfg.wid, 1'b0};
			c_s2 <= c_s1;
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
			a1_s2 <= pad_s1;
			b1_s2 <= pad_s1 + wid_s1;
			a2_s2 <= pad_s1 + big_s1;
			b2_s2 <= pad_s1 + big_s1 + wid_s1;
			c_s3 <= c_s2;
			d1_s3 <= ((hi_s2 < b1_s2) ? hi_s2 : b1_s2) - ((lo_s2 > a1_s2) ? lo_s2 : a1_s2);
			d2_s3 <= ((hi_s2 < b2_s2) ? hi_s2 : b2_s2) - ((lo_s2 > a2_s2) ? lo_s2 : a2_s2);
		end
	end
endmodule

/* rtl/pgse_queue.sv */
`timescale 1ns / 1ps
module pgse_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pgse_pkg::step_t push_item,
	output logic full,
	input  logic pop,
	output pgse_pkg::step_t head,
	output logic not_empty
);
	pgse_pkg::step_t mem [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* rtl/pgse_cordic.sv */
`timescale 1ns / 1ps
module pgse_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] phase,
	output logic done,
	output logic signed [15:0] cos_q15,
	output logic signed [15:0] sin_q15
);
	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN = 3'b010,
		C_FIN = 3'b100
	} cst_t;

	localparam int W = pgse_pkg::CordicW;

	cst_t st_q;
	logic [4:0] i_q;
	logic flip_q;
	logic signed [W-1:0] x_q, y_q, z_q, xs, ys, at;
	logic signed [W-16:0] rx, ry;
	logic [31:0] ph2;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = {2'b0, pgse_pkg::atan_turn(i_q)};
	assign rx = (W-15)'(W'(x_q + W'(16384)) >>> 15);
	assign ry = (W-15)'(W'(y_q + W'(16384)) >>> 15);
	assign ph2 = {phase[31] ^ phase[31] ^ (phase[31] ^ (phase[31] ^ phase[30])), phase[30:0]};

	function automatic logic signed [15:0] sat(input logic signed [W-16:0] v, input logic neg);
		logic signed [15:0] r;
		if (v > $signed((W-15)'(32767))) r = 16'sd32767;
		else if (v < -$signed((W-15)'(32767))) r = -16'sd32767;
		else r = v[15:0];
		return neg ? -r : r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			done <= 1'b0;
		end else begin
			done <= (st_q == C_FIN);
			unique case (st_q)
				C_IDLE: begin
					if (start) st_q <= C_RUN;
				end
				C_RUN: begin
					if (i_q == 5'(pgse_pkg::CordicIter - 1)) st_q <= C_FIN;
				end
				C_FIN: begin
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			C_IDLE: begin
				flip_q <= phase[31] ^ phase[30];
				x_q <= pgse_pkg::CordicGain;
				y_q <= '0;
				z_q <= W'($signed(ph2));
				i_q <= '0;
			end
			C_RUN: begin
				if (!z_q[W-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				i_q <= i_q + 5'd1;
			end
			C_FIN: begin
				cos_q15 <= sat(rx, flip_q);
				sin_q15 <= sat(ry, flip_q);
			end
			default: begin
			end
		endcase
	end
endmodule

/* rtl/pgse_back.sv */
`timescale 1ns / 1ps
module pgse_back (
	input  logic clk,
	input  logic arst_n,
	input  pgse_pkg::bcfg_t cfg,
	input  logic not_empty,
	input  pgse_pkg::step_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] phase_turns,
	output logic signed [47:0] signal_real,
	output logic signed [47:0] signal_imag,
	output logic walker_done
);
	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_MUL = 4'b0010,
		B_CORD = 4'b0100,
		B_EMIT = 4'b1000
	} bst_t;

	bst_t st_q;
	pgse_pkg::step_t it_q;
	logic [3:0] step_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	logic [63:0] mres_q, p_q, t_q, j_q, net64;
	logic [63:0] shr;
	logic [31:0] u_q, phase_q, rep_q, newph;
	logic signed [47:0] real_q, imag_q;
	logic cgo_q, cdone;
	logic signed [15:0] cval, sval;
	logic emit;

	assign pop = (st_q == B_IDLE) && not_empty;
	assign net64 = 64'($signed(it_q.net));
	assign mprod = ma * mb;
	assign shr = 64'($signed(mres_q) >>> 30);
	assign newph = phase_q + u_q + mres_q[31:0];
	assign emit = (st_q == B_EMIT) && (!out_valid || !out_stall);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			4'd0: begin ma = 33'($signed(cfg.dir_x)); mb = 33'($signed(it_q.dx)); end
			4'd1: begin ma = 33'($signed(cfg.dir_y)); mb = 33'($signed(it_q.dy)); end
			4'd2: begin ma = 33'($signed(cfg.dir_z)); mb = 33'($signed(it_q.dz)); end
			4'd3: begin ma = {1'b0, cfg.gamma}; mb = {1'b0, cfg.amp}; end
			4'd4: begin ma = {1'b0, mres_q[31:0]}; mb = {1'b0, net64[31:0]}; end
			4'd5: begin ma = {1'b0, p_q[31:0]}; mb = {1'b0, net64[63:32]}; end
			4'd6: begin ma = {1'b0, p_q[63:32]}; mb = {1'b0, net64[31:0]}; end
			4'd8: begin ma = {1'b0, t_q[31:0]}; mb = {1'b0, j_q[31:0]}; end
			4'd9: begin ma = {1'b0, t_q[31:0]}; mb = {1'b0, j_q[63:32]}; end
			4'd10: begin ma = {1'b0, t_q[63:32]}; mb = {1'b0, j_q[31:0]}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	pgse_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cgo_q),
		.phase(rep_q),
		.done(cdone),
		.cos_q15(cval),
		.sin_q15(sval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			step_q <= '0;
			phase_q <= '0;
			real_q <= '0;
			imag_q <= '0;
			cgo_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			cgo_q <= (st_q == B_MUL) && (step_q == 4'd11) && it_q.done;
			if (emit) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (not_empty) begin
						step_q <= '0;
						st_q <= B_MUL;
					end
				end
				B_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd11) begin
						if (it_q.done) begin
							phase_q <= '0;
							st_q <= B_CORD;
						end else begin
							phase_q <= newph;
							st_q <= B_EMIT;
						end
					end
				end
				B_CORD: begin
					if (cdone) begin
						real_q <= real_q + 48'(cval);
						imag_q <= imag_q + 48'(sval);
						st_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (emit) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mres_q <= mprod[63:0];
		if (pop) it_q <= head;
		if (st_q == B_MUL) begin
			unique case (step_q)
				4'd1: j_q <= shr;
				4'd2, 4'd3: j_q <= j_q + shr;
				4'd4: p_q <= mres_q;
				4'd5: t_q <= mres_q;
				4'd6, 4'd7: t_q[63:32] <= t_q[63:32] + mres_q[31:0];
				4'd9: u_q <= mres_q[63:32];
				4'd10: u_q <= u_q + mres_q[31:0];
				4'd11: rep_q <= newph;
				default: begin
				end
			endcase
		end
		if (emit) begin
			phase_turns <= rep_q;
			signal_real <= real_q;
			signal_imag <= imag_q;
			walker_done <= it_q.done;
		end
	end
endmodule

/* rtl/pgse_phase_accumulator.sv */
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    time_now time_prev disp_x disp_y disp_z end_of_walker
// out       out  out_valid/out_stall  phase_turns signal_real signal_imag walker_done
// cfg       in   cfg_we               cfg_index cfg_data
// A result passes through three front stages, the queue, twelve steps on the shared
// 33x33 multiplier and one output load. The back sequencer takes a new request only
// after it has emitted the last one. A walker's last step also runs the iterative
// CORDIC. Reset clears phase and sums and loads the config registers' defaults.
// A two-entry queue lets the front accept while the back works or the output stalls.
module pgse_phase_accumulator (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [31:0] time_now,
	input  logic [31:0] time_prev,
	input  logic signed [31:0] disp_x,
	input  logic signed [31:0] disp_y,
	input  logic signed [31:0] disp_z,
	input  logic end_of_walker,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] phase_turns,
	output logic signed [47:0] signal_real,
	output logic signed [47:0] signal_imag,
	output logic walker_done
);
	pgse_pkg::fcfg_t fcfg_q;
	pgse_pkg::bcfg_t bcfg_q;
	pgse_pkg::step_t push_item, head;
	logic push, full, pop, not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcfg_q <= '{dir_x: 32'h40000000, dir_y: '0, dir_z: '0, amp: '0, gamma: '0};
			fcfg_q <= '0;
		end else if (cfg_we) begin
			unique case (pgse_pkg::reg_idx_t'(cfg_index))
				pgse_pkg::REG_DIR_X: bcfg_q.dir_x <= cfg_data;
				pgse_pkg::REG_DIR_Y: bcfg_q.dir_y <= cfg_data;
				pgse_pkg::REG_DIR_Z: bcfg_q.dir_z <= cfg_data;
				pgse_pkg::REG_AMP: bcfg_q.amp <= cfg_data;
				pgse_pkg::REG_SEP: fcfg_q.sep <= cfg_data;
				pgse_pkg::REG_WID: fcfg_q.wid <= cfg_data;
				pgse_pkg::REG_TE: fcfg_q.te <= cfg_data;
				pgse_pkg::REG_GAMMA: bcfg_q.gamma <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pgse_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(fcfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.time_now(time_now),
		.time_prev(time_prev),
		.disp_x(disp_x),
		.disp_y(disp_y),
		.disp_z(disp_z),
		.end_of_walker(end_of_walker),
		.queue_full(full),
		.push(push),
		.push_item(push_item)
	);

	pgse_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(full),
		.pop(pop),
		.head(head),
		.not_empty(not_empty)
	);

	pgse_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(bcfg_q),
		.not_empty(not_empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.phase_turns(phase_turns),
		.signal_real(signal_real),
		.signal_imag(signal_imag),
		.walker_done(walker_done)
	);
endmodule

/* test/tb_pgse_phase_accumulator.sv */
`timescale 1ns / 1ps
module tb_pgse_phase_accumulator;

	typedef struct {
		bit [31:0] phase;
		bit [47:0] re;
		bit [47:0] im;
		bit done;
	} echo_t;

	class phase_scoreboard;
		bit [31:0] dir_x, dir_y, dir_z, amp, sep, wid, te, gam;
		bit [31:0] phase_acc;
		bit [47:0] real_sum, imag_sum;
		echo_t expected_q[$];
		int errors;
		bit [31:0] atan_lut[28] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
			32'h00000014, 32'h0000000A, 32'h00000005};

		function new();
			dir_x = 32'h40000000; dir_y = 0; dir_z = 0;
			amp = 0; sep = 0; wid = 0; te = 0; gam = 0;
			phase_acc = 0; real_sum = 0; imag_sum = 0; errors = 0;
		endfunction

		function void set_reg(pgse_pkg::reg_idx_t idx, bit [31:0] v);
			case (idx)
				pgse_pkg::REG_DIR_X: dir_x = v;
				pgse_pkg::REG_DIR_Y: dir_y = v;
				pgse_pkg::REG_DIR_Z: dir_z = v;
				pgse_pkg::REG_AMP: amp = v;
				pgse_pkg::REG_SEP: sep = v;
				pgse_pkg::REG_WID: wid = v;
				pgse_pkg::REG_TE: te = v;
				pgse_pkg::REG_GAMMA: gam = v;
				default: begin
				end
			endcase
		endfunction

		function longint lobe_overlap(longint lo, longint hi, longint a, longint b);
			longint d;
			d = ((hi < b) ? hi : b) - ((lo > a) ? lo : a);
			return (d > 0) ? d : 0;
		endfunction

		function longint to_q15(longint v);
			longint r;
			r = (v + 16384) >>> 15;
			if (r > 32767) r = 32767;
			if (r < -32767) r = -32767;
			return r;
		endfunction

		function void rotate(bit [31:0] ph, output longint c, output longint s);
			bit [31:0] q;
			bit flip;
			longint x, y, z, nx;
			q = ph + 32'h40000000;
			flip = q[31];
			if (flip) ph = ph - 32'h80000000;
			z = longint'(signed'(ph));
			x = 652032874;
			y = 0;
			for (int i = 0; i < 28; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - longint'(atan_lut[i]);
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + longint'(atan_lut[i]);
				end
				x = nx;
			end
			c = to_q15(x);
			s = to_q15(y);
			if (flip) begin
				c = -c;
				s = -s;
			end
		endfunction

		function void note_step(bit [31:0] tn, bit [31:0] tp, bit [31:0] dx,
				bit [31:0] dy, bit [31:0] dz, bit eow);
			longint tn2, tp2, pad2, lo, hi, net, proj, c, s;
			bit [63:0] p;
			echo_t e;
			tn2 = 2 * longint'(tn);
			tp2 = 2 * longint'(tp);
			pad2 = longint'(te) - longint'(sep) - longint'(wid);
			lo = tp2;
			hi = (tn2 < 2 * longint'(te)) ? tn2 : 2 * longint'(te);
			net = 0;
			if (hi > lo)
				net = lobe_overlap(lo, hi, pad2, pad2 + 2 * longint'(wid))
					- lobe_overlap(lo, hi, pad2 + 2 * longint'(sep),
					pad2 + 2 * longint'(sep) + 2 * longint'(wid));
			proj = ((longint'(signed'(dir_x)) * longint'(signed'(dx))) >>> 30)
				+ ((longint'(signed'(dir_y)) * longint'(signed'(dy))) >>> 30)
				+ ((longint'(signed'(dir_z)) * longint'(signed'(dz))) >>> 30);
			p = 64'(gam) * 64'(amp);
			p = p * 64'(net);
			p = p * 64'(proj);
			phase_acc = phase_acc + p[63:32];
			e.phase = phase_acc;
			if (eow) begin
				rotate(phase_acc, c, s);
				real_sum = real_sum + c[47:0];
				imag_sum = imag_sum + s[47:0];
				phase_acc = 0;
			end
			e.re = real_sum;
			e.im = imag_sum;
			e.done = eow;
			expected_q = {expected_q, e};
		endfunction

		function void check_result(echo_t got);
			echo_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result phase %h", $time, got.phase);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.phase !== e.phase) begin
				$display("%0t: phase_turns expected %h actual %h", $time, e.phase, got.phase);
				errors++;
			end
			if (got.re !== e.re) begin
				$display("%0t: signal_real expected %h actual %h", $time, e.re, got.re);
				errors++;
			end
			if (got.im !== e.im) begin
				$display("%0t: signal_imag expected %h actual %h", $time, e.im, got.im);
				errors++;
			end
			if (got.done !== e.done) begin
				$display("%0t: walker_done expected %b actual %b", $time, e.done, got.done);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = pgse_pkg::REG_DIR_X;
	logic [31:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] time_now = 0, time_prev = 0;
	logic signed [31:0] disp_x = 0, disp_y = 0, disp_z = 0;
	logic end_of_walker = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [31:0] phase_turns;
	logic signed [47:0] signal_real, signal_imag;
	logic walker_done;

	phase_scoreboard sb = new();
	int stall_mode = 0;
	int cycle_cnt = 0;

	pgse_phase_accumulator DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			2: out_stall <= ($urandom_range(0, 99) < 85);
			default: out_stall <= (cycle_cnt % 7 < 3);
		endcase
	end

	always @(posedge clk) begin
		echo_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.phase = phase_turns;
			r.re = signal_real;
			r.im = signal_imag;
			r.done = walker_done;
			sb.check_result(r);
		end
	end

	int burst_left = 0;

	task automatic push_step(bit [31:0] tn, bit [31:0] tp, bit [31:0] dx, bit [31:0] dy,
			bit [31:0] dz, bit eow);
		time_now <= tn;
		time_prev <= tp;
		disp_x <= dx;
		disp_y <= dy;
		disp_z <= dz;
		end_of_walker <= eow;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_step(tn, tp, dx, dy, dz, eow);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(pgse_pkg::reg_idx_t idx, bit [31:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic load_regs(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] a,
			bit [31:0] s, bit [31:0] w, bit [31:0] t, bit [31:0] g);
		write_reg(pgse_pkg::REG_DIR_X, x);
		write_reg(pgse_pkg::REG_DIR_Y, y);
		write_reg(pgse_pkg::REG_DIR_Z, z);
		write_reg(pgse_pkg::REG_AMP, a);
		write_reg(pgse_pkg::REG_SEP, s);
		write_reg(pgse_pkg::REG_WID, w);
		write_reg(pgse_pkg::REG_TE, t);
		write_reg(pgse_pkg::REG_GAMMA, g);
		cfg_we <= 0;
	endtask

	function automatic bit [31:0] rand_disp();
		case ($urandom_range(0, 3))
			0: return $urandom;
			default: return $urandom_range(0, 32'h07FFFFFF) - 32'h04000000;
		endcase
	endfunction

	// walkers with growing time, plus some noise steps
	task automatic run_walkers(int n_items);
		int cnt;
		longint t, span, dt;
		int steps;
		cnt = 0;
		while (cnt < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				push_step($urandom, $urandom, $urandom, $urandom, $urandom,
					1'($urandom_range(0, 1)));
				cnt++;
			end else begin
				span = 2 * longint'(sb.te) + 64;
				if (span > 64'hFFFFFFFF) span = 64'hFFFFFFFF;
				steps = $urandom_range(1, 10);
				t = $urandom_range(0, 31);
				for (int k = 0; k < steps; k++) begin
					dt = $urandom_range(0, 32'(span / 4 + 1));
					if ($urandom_range(0, 15) == 0)
						push_step(32'(t), 32'(t + dt), rand_disp(), rand_disp(), rand_disp(),
							k == steps - 1);
					else
						push_step(32'(t + dt), 32'(t), rand_disp(), rand_disp(), rand_disp(),
							k == steps - 1);
					t = t + dt;
					if (t > 64'hFFFFFFFF) t = $urandom_range(0, 100);
					cnt++;
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_walkers(120);
		drain();
		load_regs(32'h40000000, 0, 0, 1000, 20 << 16, 5 << 16, 40 << 16, 3000);
		push_step(0, 0, 0, 0, 0, 0);
		push_step(32'hFFFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
		push_step(32'hFFFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1);
		push_step(10 << 16, 20 << 16, 32'h01000000, 0, 0, 1);
		push_step(10 << 16, 10 << 16, 32'h01000000, 0, 0, 1);
		push_step(12 << 16, 0, 32'h01000000, 0, 0, 0);
		push_step(32 << 16, 12 << 16, 32'h01000000, 0, 0, 0);
		push_step(40 << 16, 0, 32'h02000000, 0, 0, 1);
		push_step(9 << 16, 8 << 16, 32'hFF000000, 0, 0, 0);
		push_step(31 << 16, 29 << 16, 32'h00400000, 0, 0, 1);
		push_step(32'hFFFFFFFF, 32'hFFFFFFFE, 32'h01000000, 0, 0, 1);
		for (int k = 0; k < 8; k++)
			push_step((k + 1) << 18, k << 18, $urandom, $urandom, $urandom, k == 7);
		drain();
		run_walkers(150);
		drain();
		load_regs(32'hC0000000, 32'h40000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_step(32'hFFFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
		run_walkers(150);
		drain();
		load_regs(32'h20000000, 32'hE0000000, 32'h2D413CCD, 12345, 20 << 16, 5 << 16,
			10 << 16, 777777);
		run_walkers(150);
		drain();
		load_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1 << 22),
			$urandom_range(0, 1 << 21), $urandom_range(0, 1 << 23), $urandom);
		run_walkers(150);
		drain();
		load_regs(0, 0, 0, 0, 0, 0, 0, 0);
		run_walkers(60);
		drain();
		load_regs(32'h40000000, 32'h40000000, 32'hC0000000, $urandom, 3 << 16, 1 << 16,
			6 << 16, $urandom);
		run_walkers(120);
		drain();
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb_pgse_phase_accumulator OK");
		end else begin
			$display("tb_pgse_phase_accumulator NOT OK");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb_pgse_phase_accumulator NOT OK");
		$finish;
	end
endmodule

/* files.f */
rtl/pgse_pkg.sv
rtl/pgse_front.sv
rtl/pgse_queue.sv
rtl/pgse_cordic.sv
rtl/pgse_back.sv
rtl/pgse_phase_accumulator.sv
test/tb_pgse_phase_accumulator.sv
